@@ src/tss_pkg.sv @@
package tss_pkg;

  // Argument and result format: signed Q3.28 in a 32-bit word
  localparam int FRAC_BITS = 28;
  localparam int XW        = 32;

  // Configuration register
  localparam int              TCW             = 5;
  localparam logic [TCW-1:0]  TERM_COUNT_RST  = 5'd5;
  localparam int              MAX_TERMS_DEF   = 16;
  localparam int              ADDR_W          = 3;
  localparam logic [ADDR_W-1:0] ADDR_TERM_COUNT = 3'd0;
  localparam int              PDW             = 32;

  // Internal widths. |x| <= 8 in Q3.28, so x^2 <= 2^34, every term stays
  // below 417 * 2^28 < 2^37 and the running sum below 2^40.
  localparam int M2W = 35;   // x^2 magnitude
  localparam int TW  = 37;   // term magnitude
  localparam int PW  = 43;   // term * x^2 before the divide
  localparam int SW  = 42;   // signed running sum

  // Divide by (2j)(2j+1) as a multiply by ceil(2^RSH / d): exact for
  // dividends below 2^PW and divisors below 2^13.
  localparam int RSH = 56;
  localparam int RW  = 54;

  // Shared multiplier: AW x BW operands, taken as two by two chunks
  localparam int AC  = 22;
  localparam int BC  = 36;
  localparam int AW  = 2 * AC;
  localparam int BW  = 2 * BC;
  localparam int PRW = AW + BW;

  typedef struct packed {
    logic          start;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic           done;
    logic [PRW-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [XW-1:0] sine_value;
    logic                 saturated;
  } res_t;

endpackage

@@ src/tss_if.sv @@
interface tss_in_if;
  import tss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface tss_out_if;
  import tss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] sine_value;
  logic                 saturated;

  modport source (output valid, output sine_value, output saturated, input ready);
  modport sink   (input valid, input sine_value, input saturated, output ready);
endinterface

@@ src/tss_mul.sv @@
module tss_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  tss_pkg::mul_req_t req,
  output tss_pkg::mul_rsp_t rsp
);
  import tss_pkg::*;

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]  a_r, a_nxt;
  logic [BW-1:0]  b_r, b_nxt;
  logic [PRW-1:0] acc_r, acc_nxt;

  logic [AC-1:0]      a_chunk;
  logic [BC-1:0]      b_chunk;
  logic [AC+BC-1:0]   pp;
  logic [PRW-1:0]     pp_aligned;

  // cnt_r[1] picks the chunk of a, cnt_r[0] the chunk of b
  assign a_chunk = cnt_r[1] ? a_r[AW-1:AC] : a_r[AC-1:0];
  assign b_chunk = cnt_r[0] ? b_r[BW-1:BC] : b_r[BC-1:0];
  assign pp      = a_chunk * b_chunk;

  always_comb begin
    case (cnt_r)
      2'd0:    pp_aligned = PRW'(pp);
      2'd1:    pp_aligned = PRW'(pp) << BC;
      2'd2:    pp_aligned = PRW'(pp) << AC;
      2'd3:    pp_aligned = PRW'(pp) << (AC + BC);
      default: pp_aligned = '0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp_aligned;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

@@ src/tss_core.sv @@
module tss_core #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [tss_pkg::XW-1:0] x_value,
  input  logic [tss_pkg::TCW-1:0]      term_count,
  output logic                         idle,
  output logic                         res_valid,
  output tss_pkg::res_t                res,
  input  logic                         res_ready,
  output tss_pkg::mul_req_t            mul_req,
  input  tss_pkg::mul_rsp_t            mul_rsp
);
  import tss_pkg::*;

  localparam int JW = $clog2(MAX_TERMS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_TM   = 3'd2;
  localparam logic [2:0] S_DV   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic                 neg_r, neg_nxt;
  logic [TW-1:0]        term_r, term_nxt;
  logic [M2W-1:0]       m2_r, m2_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [JW-1:0]        j_r, j_nxt;
  logic [JW-1:0]        n_r, n_nxt;

  logic [XW-1:0]        x_u, mag;
  logic [TCW:0]         tc_ext;
  logic [JW-1:0]        n_clamp;
  logic [M2W-1:0]       m2_new;
  logic [TW-1:0]        term_new;
  logic signed [SW-1:0] t_ext;
  logic                 tneg;
  logic                 over;

  // ceil(2^RSH / ((2j)(2j+1))); entry zero is never read
  logic [RW-1:0] recip [MAX_TERMS+1];

  for (genvar g = 0; g <= MAX_TERMS; g++) begin : g_recip
    localparam longint unsigned DIV = (g == 0) ? 64'd1 : 64'(2 * g) * 64'(2 * g + 1);
    localparam longint unsigned RV  = ((64'd1 << RSH) + DIV - 64'd1) / DIV;
    assign recip[g] = RW'(RV);
  end

  assign x_u     = x_value;
  assign mag     = x_u[XW-1] ? (~x_u + XW'(1)) : x_u;
  assign tc_ext  = {1'b0, term_count};
  assign n_clamp = (tc_ext > (TCW+1)'(MAX_TERMS)) ? JW'(MAX_TERMS) : JW'(tc_ext);

  assign m2_new   = mul_rsp.prod[FRAC_BITS +: M2W];
  assign term_new = mul_rsp.prod[RSH +: TW];
  assign tneg     = neg_r ^ j_r[0];
  assign t_ext    = signed'(SW'(term_new));

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    term_nxt      = term_r;
    m2_nxt        = m2_r;
    sum_nxt       = sum_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt       = x_u[XW-1];
          term_nxt      = TW'(mag);
          n_nxt         = n_clamp;
          mul_req.start = 1'b1;
          mul_req.a     = AW'(mag);
          mul_req.b     = BW'(mag);
          state_nxt     = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_rsp.done) begin
          m2_nxt  = m2_new;
          sum_nxt = neg_r ? -signed'(SW'(term_r)) : signed'(SW'(term_r));
          if (n_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt         = JW'(1);
            mul_req.start = 1'b1;
            mul_req.a     = AW'(term_r);
            mul_req.b     = BW'(m2_new);
            state_nxt     = S_TM;
          end
        end
      end
      S_TM: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = AW'(mul_rsp.prod[FRAC_BITS +: PW]);
          mul_req.b     = BW'(recip[j_r]);
          state_nxt     = S_DV;
        end
      end
      S_DV: begin
        if (mul_rsp.done) begin
          term_nxt = term_new;
          sum_nxt  = tneg ? (sum_r - t_ext) : (sum_r + t_ext);
          if (j_r == n_r) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt         = j_r + JW'(1);
            mul_req.start = 1'b1;
            mul_req.a     = AW'(term_new);
            mul_req.b     = BW'(m2_r);
            state_nxt     = S_TM;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    term_r <= term_nxt;
    m2_r   <= m2_nxt;
    sum_r  <= sum_nxt;
    j_r    <= j_nxt;
    n_r    <= n_nxt;
  end

  // Clip to 32 bits when the bits above the sign do not agree
  assign over = !((&sum_r[SW-1:XW-1]) || !(|sum_r[SW-1:XW-1]));

  always_comb begin
    res.saturated = over;
    if (!over) begin
      res.sine_value = sum_r[XW-1:0];
    end else if (sum_r[SW-1]) begin
      res.sine_value = {1'b1, {(XW-1){1'b0}}};
    end else begin
      res.sine_value = {1'b0, {(XW-1){1'b1}}};
    end
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

endmodule

@@ src/taylor_series_sine.sv @@
// Sine by truncated Maclaurin series, signed Q3.28 in and out.
// in_ch  : one word per argument x_value; ready is high only while the
//          sequencer is idle, so one argument is in flight at a time.
// out_ch : one word per argument, sine_value plus a saturated flag that
//          marks a sum clipped to the 32-bit range.
// cfg_*  : APB-style port, one register term_count at byte address 0
//          (highest term index N, clipped to MAX_TERMS; N+1 terms).
//
// All arithmetic goes through one 22x36 multiplier that builds each wide
// product from four chunk products. x^2 takes one product, and every
// further term takes two: term * x^2, then a multiply by the reciprocal
// of (2j)(2j+1) from a constant table.
//
// Reset sets term_count to 5 and empties the output register. When the
// receiver stalls, the output register holds its word; the next argument
// is still taken and its result waits in the sequencer until the output
// register frees up.
module taylor_series_sine #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tss_in_if.sink                          in_ch,
  tss_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tss_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [tss_pkg::PDW-1:0]         cfg_pwdata,
  output logic [tss_pkg::PDW-1:0]         cfg_prdata,
  output logic                            cfg_pready
);
  import tss_pkg::*;

  localparam logic [XW-1:0] SINE_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam logic [XW-1:0] SINE_MIN = {1'b1, {(XW-1){1'b0}}};

  logic [TCW-1:0]       term_count_r, term_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [XW-1:0] out_sine_r, out_sine_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic     core_idle;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // Config: write lands on the access cycle; no wait states
  assign cfg_pready = 1'b1;

  always_comb begin
    term_count_nxt = term_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_TERM_COUNT)) begin
      term_count_nxt = cfg_pwdata[TCW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_TERM_COUNT) ? PDW'(term_count_r) : '0;

  tss_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  tss_core #(
    .MAX_TERMS (MAX_TERMS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_ch.valid && core_idle),
    .x_value    (in_ch.x_value),
    .term_count (term_count_r),
    .idle       (core_idle),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp)
  );

  assign in_ch.ready = core_idle;

  // Output register: load a finished word when empty or being drained,
  // hold it while the receiver stalls
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sine_nxt  = out_sine_r;
    out_sat_nxt   = out_sat_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_sine_nxt  = res.sine_value;
      out_sat_nxt   = res.saturated;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      term_count_r <= term_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sine_r <= out_sine_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sine_value = out_sine_r;
  assign out_ch.saturated  = out_sat_r;

  // A clipped word sits at one end of the range
  a_sat_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (out_ch.sine_value == SINE_MAX || out_ch.sine_value == SINE_MIN))
    else $error("saturated word not at a range end");

  // Taking an argument starts the sequencer; it is busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("ready stayed high after an argument was taken");

  // A new result word only arrives out of a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result word appeared while the sequencer was idle");

endmodule
